// ===== rtl/descreening_integral_kernel_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Descreening integral kernel assertion macros
// Shared property macros for the kernel unit; empty when assertions are off.
// ----------------------------------------------------------------------------
`ifndef DESCREENING_INTEGRAL_KERNEL_UNIT_ASSERT_SVH
`define DESCREENING_INTEGRAL_KERNEL_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication on the unit clock.
`define DIK_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("descreening kernel assertion failed");
// Next-cycle implication on the unit clock.
`define DIK_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("descreening kernel assertion failed");
`else
`define DIK_ASSERT_IMPL(lbl, ante, cons)
`define DIK_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== rtl/dik_pkg.sv =====
// ----------------------------------------------------------------------------
// Descreening integral kernel package
// Types and constants shared by the front end, queue, sequencer and arithmetic.
// ----------------------------------------------------------------------------
package dik_pkg;

  localparam int unsigned FIELD_W  = 24;
  localparam int unsigned VALUE_W  = 48;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned QDEPTH   = 4;
  localparam int unsigned QPTR_W   = 2;

  localparam logic [63:0] LIM       = 64'h1000_0000_0000_0000;
  localparam logic [63:0] ONE_S     = 64'h0000_0000_4000_0000;
  localparam logic [63:0] LN2_Q32   = 64'd2977044472;
  localparam logic [63:0] TWOPI_Q32 = 64'd26986075409;
  localparam logic [VALUE_W-1:0] OUT_MAX = 48'h7FFF_FFFF_FFFF;
  localparam logic [VALUE_W-1:0] OUT_MIN = 48'h8000_0000_0000;

  localparam logic [0:0] REG_SWITCH_START = 1'b0;
  localparam logic [0:0] REG_SWITCH_END   = 1'b1;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_ZERO_RADIUS = 2'd1,
    ST_SAT         = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    CL_ZERO_RAD,
    CL_ZERO_OUT,
    CL_SEP,
    CL_OVL,
    CL_INC_SER,
    CL_INC_LOG
  } cls_e;

  typedef struct packed {
    logic [FIELD_W-1:0] r;
    logic [FIELD_W-1:0] a;
    logic [FIELD_W-1:0] b;
    cls_e               cls;
    logic               sone;
  } q_item_t;

  typedef enum logic [1:0] {
    OP_MUL,
    OP_DIV,
    OP_LOG
  } op_kind_e;

  typedef struct packed {
    op_kind_e    kind;
    logic [63:0] x;
    logic [63:0] y;
    logic [5:0]  amt;
  } op_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] res;
    logic        ovf;
  } op_rsp_t;

endpackage

// ===== rtl/dik_front.sv =====
// ----------------------------------------------------------------------------
// Descreening kernel front end
// Accepts atom pairs and sorts them into the integral branch to be evaluated.
// ----------------------------------------------------------------------------
module dik_front (
  input  logic                         start_i,
  input  logic                         full_i,
  input  logic [dik_pkg::FIELD_W-1:0]  r_i,
  input  logic [dik_pkg::FIELD_W-1:0]  a_i,
  input  logic [dik_pkg::FIELD_W-1:0]  b_i,
  input  logic [dik_pkg::FIELD_W-1:0]  sw_start_i,
  input  logic [dik_pkg::FIELD_W-1:0]  sw_end_i,
  output logic                         push_o,
  output dik_pkg::q_item_t             item_o
);
  import dik_pkg::*;

  logic [FIELD_W:0]   sum_ab;
  logic [FIELD_W-1:0] diff_ab;
  logic [33:0]        r_k;

  assign sum_ab  = {1'b0, a_i} + {1'b0, b_i};
  assign diff_ab = (b_i > a_i) ? b_i - a_i : a_i - b_i;
  // Thousand times the distance, built from shifts.
  assign r_k     = ({10'b0, r_i} << 10) - ({10'b0, r_i} << 4) - ({10'b0, r_i} << 3);
  assign push_o  = start_i && !full_i;

  always_comb begin
    item_o.r    = r_i;
    item_o.a    = a_i;
    item_o.b    = b_i;
    item_o.sone = (r_i < sw_start_i) || (sw_end_i == sw_start_i);
    if (a_i == '0 || b_i == '0) begin
      item_o.cls = CL_ZERO_RAD;
    end else if (r_i > sw_end_i) begin
      item_o.cls = CL_ZERO_OUT;
    end else if ({1'b0, r_i} > sum_ab) begin
      item_o.cls = CL_SEP;
    end else if (r_i > diff_ab) begin
      item_o.cls = CL_OVL;
    end else if (a_i > b_i) begin
      item_o.cls = CL_ZERO_OUT;
    end else if (r_k < {10'b0, b_i}) begin
      item_o.cls = CL_INC_SER;
    end else begin
      item_o.cls = CL_INC_LOG;
    end
  end

endmodule

// ===== rtl/dik_fifo.sv =====
// ----------------------------------------------------------------------------
// Descreening kernel item queue
// Short first-in first-out queue between the front end and the sequencer.
// ----------------------------------------------------------------------------
module dik_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  dik_pkg::q_item_t item_i,
  input  logic             pop_i,
  output dik_pkg::q_item_t item_o,
  output logic             empty_o,
  output logic             full_o
);
  import dik_pkg::*;

  q_item_t             mem_q [QDEPTH];
  logic [QPTR_W-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [QPTR_W:0]     cnt_q, cnt_d;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == (QPTR_W+1)'(QDEPTH));
  assign item_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = push_i ? wr_q + 1'b1 : wr_q;
    rd_d  = pop_i ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q + {{QPTR_W{1'b0}}, push_i} - {{QPTR_W{1'b0}}, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= item_i;
    end
  end

endmodule

// ===== rtl/dik_arith.sv =====
// ----------------------------------------------------------------------------
// Descreening kernel arithmetic unit
// Shared 32x32 multiplier, bit-serial fractional divider and log2 unit.
// ----------------------------------------------------------------------------
module dik_arith (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  dik_pkg::op_req_t req_i,
  output dik_pkg::op_rsp_t rsp_o
);
  import dik_pkg::*;

  typedef enum logic [2:0] {U_IDLE, U_MUL, U_MFIN, U_DIV, U_LOG} ustate_e;

  ustate_e      st_q;
  logic [6:0]   cnt_q;
  logic         done_q;
  logic [63:0]  x_q, y_q, res_q;
  logic [5:0]   amt_q;
  logic         ovf_q;
  logic [127:0] prod_q;
  logic [63:0]  rem_q, dv_q, quo_q;
  logic         sticky_q;
  logic [31:0]  m_q, frac_q;
  logic [4:0]   p_q;

  logic [31:0]  mul_a, mul_b;
  logic [63:0]  mul_p;
  logic [127:0] pp_sh, sp;
  logic [64:0]  rs;
  logic         qb;
  logic [63:0]  rem_n, quo_n;
  logic         stk_n;
  logic [32:0]  sq;
  logic [31:0]  m_n, frac_n;
  logic [4:0]   msb;
  logic [31:0]  norm;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (st_q)
      U_MUL: begin
        mul_a = cnt_q[1] ? x_q[63:32] : x_q[31:0];
        mul_b = cnt_q[0] ? y_q[63:32] : y_q[31:0];
      end
      U_LOG: begin
        mul_a = m_q;
        mul_b = m_q;
      end
      default: ;
    endcase
  end

  assign mul_p = {32'b0, mul_a} * {32'b0, mul_b};

  always_comb begin
    case (cnt_q[1:0])
      2'd0:    pp_sh = {64'b0, mul_p};
      2'd3:    pp_sh = {mul_p, 64'b0};
      default: pp_sh = {32'b0, mul_p, 32'b0};
    endcase
  end

  assign sp = prod_q >> amt_q;

  // One restoring division step per cycle.
  assign rs    = {rem_q, dv_q[63]};
  assign qb    = (rs >= {1'b0, y_q});
  assign rem_n = qb ? rs[63:0] - y_q : rs[63:0];
  assign quo_n = {quo_q[62:0], qb};
  assign stk_n = sticky_q | quo_q[63];

  // One squaring step of the mantissa per cycle.
  assign sq     = mul_p[63:31];
  assign m_n    = sq[32] ? sq[32:1] : sq[31:0];
  assign frac_n = {frac_q[30:0], sq[32]};

  always_comb begin
    msb = '0;
    for (int i = 0; i < 32; i++) begin
      if (req_i.x[i]) begin
        msb = 5'(i);
      end
    end
  end

  assign norm = req_i.x[31:0] << (5'd31 - msb);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= U_IDLE;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (st_q)
        U_IDLE: begin
          if (start_i) begin
            unique case (req_i.kind)
              OP_MUL: begin
                st_q  <= U_MUL;
                cnt_q <= '0;
              end
              OP_DIV: begin
                st_q  <= U_DIV;
                cnt_q <= 7'd64 + {1'b0, req_i.amt};
              end
              default: begin
                st_q  <= U_LOG;
                cnt_q <= 7'd32;
              end
            endcase
          end
        end
        U_MUL: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q[1:0] == 2'd3) begin
            st_q <= U_MFIN;
          end
        end
        U_MFIN: begin
          st_q   <= U_IDLE;
          done_q <= 1'b1;
        end
        U_DIV, U_LOG: begin
          cnt_q <= cnt_q - 1'b1;
          if (cnt_q == 7'd1) begin
            st_q   <= U_IDLE;
            done_q <= 1'b1;
          end
        end
        default: st_q <= U_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (st_q)
      U_IDLE: begin
        x_q      <= req_i.x;
        y_q      <= req_i.y;
        amt_q    <= req_i.amt;
        prod_q   <= '0;
        rem_q    <= '0;
        dv_q     <= req_i.x;
        quo_q    <= '0;
        sticky_q <= 1'b0;
        m_q      <= norm;
        p_q      <= msb;
        frac_q   <= '0;
      end
      U_MUL: prod_q <= prod_q + pp_sh;
      U_MFIN: begin
        if (sp > {64'b0, LIM}) begin
          res_q <= LIM;
          ovf_q <= 1'b1;
        end else begin
          res_q <= sp[63:0];
          ovf_q <= 1'b0;
        end
      end
      U_DIV: begin
        rem_q    <= rem_n;
        dv_q     <= {dv_q[62:0], 1'b0};
        quo_q    <= quo_n;
        sticky_q <= stk_n;
        if (stk_n || quo_n > LIM) begin
          res_q <= LIM;
          ovf_q <= 1'b1;
        end else begin
          res_q <= quo_n;
          ovf_q <= 1'b0;
        end
      end
      U_LOG: begin
        m_q    <= m_n;
        frac_q <= frac_n;
        res_q  <= {27'b0, p_q, frac_n};
        ovf_q  <= 1'b0;
      end
      default: ;
    endcase
  end

  assign rsp_o.done = done_q;
  assign rsp_o.res  = res_q;
  assign rsp_o.ovf  = ovf_q;

endmodule

// ===== rtl/dik_seq.sv =====
// ----------------------------------------------------------------------------
// Descreening kernel sequencer
// Steps each queued pair through its operation list on the arithmetic unit.
// ----------------------------------------------------------------------------
module dik_seq #(
  parameter int unsigned DIST_FRAC_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  dik_pkg::q_item_t              item_i,
  input  logic                          empty_i,
  output logic                          pop_o,
  input  logic [dik_pkg::FIELD_W-1:0]   sw_start_i,
  input  logic [dik_pkg::FIELD_W-1:0]   sw_end_i,
  output logic                          op_start_o,
  output dik_pkg::op_req_t              op_req_o,
  input  dik_pkg::op_rsp_t              op_rsp_i,
  output logic                          done_o,
  output logic [dik_pkg::VALUE_W-1:0]   value_o,
  output dik_pkg::status_e              status_o
);
  import dik_pkg::*;

  localparam logic [5:0] AMT_INV = 6'(32 + DIST_FRAC_BITS);
  localparam logic [5:0] AMT_F   = 6'(DIST_FRAC_BITS);
  localparam logic [5:0] AMT_FM1 = 6'(DIST_FRAC_BITS - 1);

  typedef enum logic [1:0] {S_IDLE, S_ISSUE, S_WAIT} sstate_e;
  typedef enum logic [2:0] {PR_FACTOR, PR_SEP, PR_OVL, PR_INCS, PR_INCL, PR_FINAL} prog_e;
  typedef enum logic [3:0] {D_T0, D_T1, D_T2, D_T3, D_ADD, D_SUB, D_WADD, D_S, D_RES} dst_e;

  sstate_e            st_q, st_d;
  prog_e              prog_q, prog_d;
  logic [3:0]         step_q, step_d;
  q_item_t            it_q, it_d;
  logic [63:0]        t0_q, t0_d, t1_q, t1_d, t2_q, t2_d, t3_q, t3_d;
  logic signed [63:0] acc_q, acc_d;
  logic               ovf_q, ovf_d, wneg_q, wneg_d;
  logic [30:0]        s_q, s_d;
  logic               done_q, done_d;
  logic [VALUE_W-1:0] value_q, value_d;
  status_e            status_q, status_d;

  logic [63:0]        r64, a64, b64, u1, u2s, u2i, rb, wm, absacc, s_new;
  logic signed [63:0] pcoef, ap, w;
  dst_e               dst;
  logic               last;

  function automatic prog_e branch_prog(input cls_e c);
    prog_e p;
    unique case (c)
      CL_SEP:     p = PR_SEP;
      CL_OVL:     p = PR_OVL;
      CL_INC_SER: p = PR_INCS;
      default:    p = PR_INCL;
    endcase
    return p;
  endfunction

  assign r64    = {40'b0, it_q.r};
  assign a64    = {40'b0, it_q.a};
  assign b64    = {40'b0, it_q.b};
  assign u1     = r64 + b64;
  assign u2s    = r64 - b64;
  assign u2i    = b64 - r64;
  assign rb     = (r64 > b64) ? u2s : u2i;
  assign pcoef  = $signed(64'd10 << 30) - $signed(t0_q * 64'd15) + $signed(t1_q * 64'd6);
  assign ap     = (r64 > b64) ? -$signed(t2_q) : $signed(t2_q);
  assign w      = ap - $signed({1'b0, t0_q[63:1]});
  assign wm     = w[63] ? 64'(-w) : 64'(w);
  assign absacc = acc_q[63] ? 64'(-acc_q) : 64'(acc_q);

  // Operation list of each program.
  always_comb begin
    op_req_o.kind = OP_MUL;
    op_req_o.x    = '0;
    op_req_o.y    = '0;
    op_req_o.amt  = '0;
    dst           = D_T0;
    last          = 1'b0;
    case (prog_q)
      PR_FACTOR: begin
        case (step_q)
          4'd0: begin
            op_req_o.kind = OP_DIV;
            op_req_o.x    = {40'b0, it_q.r - sw_start_i};
            op_req_o.y    = {40'b0, sw_end_i - sw_start_i};
            op_req_o.amt  = 6'd30;
          end
          4'd1: begin
            op_req_o.x = t0_q; op_req_o.y = t0_q; op_req_o.amt = 6'd30; dst = D_T1;
          end
          4'd2: begin
            op_req_o.x = t1_q; op_req_o.y = t0_q; op_req_o.amt = 6'd30; dst = D_T2;
          end
          default: begin
            op_req_o.x   = t2_q;
            op_req_o.y   = pcoef[63] ? 64'd0 : 64'(pcoef);
            op_req_o.amt = 6'd30;
            dst          = D_S;
            last         = 1'b1;
          end
        endcase
      end
      PR_SEP: begin
        case (step_q)
          4'd0: begin op_req_o.x = u1; op_req_o.y = u2s; end
          4'd1: begin
            op_req_o.kind = OP_DIV; op_req_o.x = b64; op_req_o.y = t0_q;
            op_req_o.amt = AMT_INV; dst = D_ADD;
          end
          4'd2: begin op_req_o.kind = OP_LOG; op_req_o.x = u1; dst = D_T1; end
          4'd3: begin op_req_o.kind = OP_LOG; op_req_o.x = u2s; dst = D_T2; end
          4'd4: begin
            op_req_o.x = t1_q - t2_q; op_req_o.y = LN2_Q32; op_req_o.amt = 6'd32; dst = D_T1;
          end
          default: begin
            op_req_o.kind = OP_DIV; op_req_o.x = t1_q; op_req_o.y = r64;
            op_req_o.amt = AMT_FM1; dst = D_SUB; last = 1'b1;
          end
        endcase
      end
      PR_OVL: begin
        case (step_q)
          4'd0: begin
            op_req_o.kind = OP_DIV; op_req_o.x = 64'd1; op_req_o.y = a64;
            op_req_o.amt = AMT_INV; dst = D_ADD;
          end
          4'd1: begin
            op_req_o.kind = OP_DIV; op_req_o.x = 64'd1; op_req_o.y = u1;
            op_req_o.amt = AMT_INV; dst = D_SUB;
          end
          4'd2: begin op_req_o.x = u1; op_req_o.y = u1; dst = D_T0; end
          4'd3: begin op_req_o.x = a64; op_req_o.y = a64; dst = D_T1; end
          4'd4: begin
            op_req_o.kind = OP_DIV; op_req_o.x = t0_q - t1_q; op_req_o.y = t1_q << 2;
            op_req_o.amt = 6'd32; dst = D_T2;
          end
          4'd5: begin
            op_req_o.kind = OP_DIV; op_req_o.x = rb; op_req_o.y = u1;
            op_req_o.amt = 6'd32; dst = D_T3;
          end
          4'd6: begin
            op_req_o.x = t2_q; op_req_o.y = t3_q; op_req_o.amt = 6'd32; dst = D_T2;
          end
          4'd7: begin op_req_o.kind = OP_LOG; op_req_o.x = u1; dst = D_T0; end
          4'd8: begin op_req_o.kind = OP_LOG; op_req_o.x = a64; dst = D_T1; end
          4'd9: begin
            op_req_o.x = t0_q - t1_q; op_req_o.y = LN2_Q32; op_req_o.amt = 6'd32; dst = D_T0;
          end
          default: begin
            op_req_o.kind = OP_DIV; op_req_o.x = wm; op_req_o.y = r64;
            op_req_o.amt = AMT_F; dst = D_WADD; last = 1'b1;
          end
        endcase
      end
      PR_INCS, PR_INCL: begin
        case (step_q)
          4'd0: begin
            op_req_o.kind = OP_DIV; op_req_o.x = 64'd2; op_req_o.y = a64;
            op_req_o.amt = AMT_INV; dst = D_ADD;
          end
          4'd1: begin op_req_o.x = u1; op_req_o.y = u2i; dst = D_T0; end
          4'd2: begin
            op_req_o.kind = OP_DIV; op_req_o.x = b64; op_req_o.y = t0_q;
            op_req_o.amt = AMT_INV; dst = D_SUB;
          end
          default: begin
            if (prog_q == PR_INCS) begin
              case (step_q)
                4'd3: begin
                  op_req_o.kind = OP_DIV; op_req_o.x = 64'd1; op_req_o.y = b64;
                  op_req_o.amt = AMT_INV; dst = D_SUB;
                end
                4'd4: begin op_req_o.x = r64; op_req_o.y = r64; dst = D_T0; end
                4'd5: begin op_req_o.x = b64; op_req_o.y = b64; dst = D_T1; end
                4'd6: begin
                  op_req_o.kind = OP_DIV; op_req_o.x = t0_q << 1;
                  op_req_o.y = (t1_q << 1) + t1_q; op_req_o.amt = 6'd32; dst = D_T2;
                end
                default: begin
                  op_req_o.kind = OP_DIV; op_req_o.x = t2_q; op_req_o.y = b64;
                  op_req_o.amt = AMT_F; dst = D_SUB; last = 1'b1;
                end
              endcase
            end else begin
              case (step_q)
                4'd3: begin op_req_o.kind = OP_LOG; op_req_o.x = u1; dst = D_T1; end
                4'd4: begin op_req_o.kind = OP_LOG; op_req_o.x = u2i; dst = D_T2; end
                4'd5: begin
                  op_req_o.x = t1_q - t2_q; op_req_o.y = LN2_Q32;
                  op_req_o.amt = 6'd32; dst = D_T1;
                end
                default: begin
                  op_req_o.kind = OP_DIV; op_req_o.x = t1_q; op_req_o.y = r64;
                  op_req_o.amt = AMT_FM1; dst = D_SUB; last = 1'b1;
                end
              endcase
            end
          end
        endcase
      end
      default: begin
        if (step_q == 4'd0) begin
          op_req_o.x = absacc; op_req_o.y = TWOPI_Q32; op_req_o.amt = 6'd32; dst = D_T0;
        end else begin
          op_req_o.x = t0_q; op_req_o.y = {33'b0, s_q}; op_req_o.amt = 6'd30;
          dst = D_RES; last = 1'b1;
        end
      end
    endcase
  end

  assign s_new = (op_rsp_i.res >= ONE_S) ? 64'd0 : ONE_S - op_rsp_i.res;

  always_comb begin
    st_d       = st_q;
    prog_d     = prog_q;
    step_d     = step_q;
    it_d       = it_q;
    t0_d       = t0_q;
    t1_d       = t1_q;
    t2_d       = t2_q;
    t3_d       = t3_q;
    acc_d      = acc_q;
    ovf_d      = ovf_q;
    wneg_d     = wneg_q;
    s_d        = s_q;
    done_d     = 1'b0;
    value_d    = value_q;
    status_d   = status_q;
    pop_o      = 1'b0;
    op_start_o = 1'b0;
    unique case (st_q)
      S_IDLE: begin
        if (!empty_i) begin
          pop_o = 1'b1;
          case (item_i.cls)
            CL_ZERO_RAD: begin
              done_d = 1'b1; value_d = '0; status_d = ST_ZERO_RADIUS;
            end
            CL_ZERO_OUT: begin
              done_d = 1'b1; value_d = '0; status_d = ST_OK;
            end
            default: begin
              it_d   = item_i;
              acc_d  = '0;
              ovf_d  = 1'b0;
              s_d    = ONE_S[30:0];
              prog_d = item_i.sone ? branch_prog(item_i.cls) : PR_FACTOR;
              step_d = '0;
              st_d   = S_ISSUE;
            end
          endcase
        end
      end
      S_ISSUE: begin
        op_start_o = 1'b1;
        wneg_d     = w[63];
        st_d       = S_WAIT;
      end
      S_WAIT: begin
        if (op_rsp_i.done) begin
          if (prog_q != PR_FACTOR) begin
            ovf_d = ovf_q | op_rsp_i.ovf;
          end
          st_d   = S_ISSUE;
          step_d = step_q + 1'b1;
          case (dst)
            D_T0:   t0_d = op_rsp_i.res;
            D_T1:   t1_d = op_rsp_i.res;
            D_T2:   t2_d = op_rsp_i.res;
            D_T3:   t3_d = op_rsp_i.res;
            D_ADD:  acc_d = acc_q + $signed(op_rsp_i.res);
            D_SUB:  acc_d = acc_q - $signed(op_rsp_i.res);
            D_WADD: acc_d = wneg_q ? acc_q - $signed(op_rsp_i.res)
                                   : acc_q + $signed(op_rsp_i.res);
            D_S: begin
              s_d = s_new[30:0];
              if (s_new == '0) begin
                done_d = 1'b1; value_d = '0; status_d = ST_OK; st_d = S_IDLE;
              end
            end
            default: begin
              st_d   = S_IDLE;
              done_d = 1'b1;
              if (ovf_q || op_rsp_i.ovf || op_rsp_i.res > {16'b0, OUT_MAX}) begin
                status_d = ST_SAT;
                value_d  = acc_q[63] ? OUT_MIN : OUT_MAX;
              end else begin
                status_d = ST_OK;
                value_d  = acc_q[63] ? -op_rsp_i.res[VALUE_W-1:0]
                                     : op_rsp_i.res[VALUE_W-1:0];
              end
            end
          endcase
          if (last) begin
            step_d = '0;
            prog_d = (prog_q == PR_FACTOR) ? branch_prog(it_q.cls) : PR_FINAL;
          end
        end
      end
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= S_IDLE;
      prog_q   <= PR_FACTOR;
      step_q   <= '0;
      done_q   <= 1'b0;
      status_q <= ST_OK;
      value_q  <= '0;
    end else begin
      st_q     <= st_d;
      prog_q   <= prog_d;
      step_q   <= step_d;
      done_q   <= done_d;
      status_q <= status_d;
      value_q  <= value_d;
    end
  end

  always_ff @(posedge clk_i) begin
    it_q   <= it_d;
    t0_q   <= t0_d;
    t1_q   <= t1_d;
    t2_q   <= t2_d;
    t3_q   <= t3_d;
    acc_q  <= acc_d;
    ovf_q  <= ovf_d;
    wneg_q <= wneg_d;
    s_q    <= s_d;
  end

  assign done_o   = done_q;
  assign value_o  = value_q;
  assign status_o = status_q;

endmodule

// ===== rtl/descreening_integral_kernel_unit.sv =====
// ----------------------------------------------------------------------------
// Descreening integral kernel unit
// Switched pairwise descreening integral for a stream of atom pairs.
// ----------------------------------------------------------------------------
// An atom pair is offered on distance_i and the two radius ports with start
// high; the item is taken on a clock edge where start is high and busy is low.
// The front end sorts each item into its integral branch at once and places
// it in a four-entry queue, so busy only rises while that queue is full.
// The sequencer takes items from the queue in order. A zero radius, a distance
// beyond switch_end or a larger screened radius inside the screener gives its
// result without the arithmetic unit when the sequencer is free: the sequencer
// pops it from the queue and registers the result. Other items run their
// operation list on one shared arithmetic unit: a 32x32 multiplier, also used
// for log2, and a one-bit-a-cycle divider. That unit sets the rate; the
// sequencer runs one such item at a time while the queue keeps taking new items.
// Each result is shown on value_o and status_o for one cycle with done_o high;
// the receiver cannot stall, and results leave in acceptance order.
// Configuration writes on the cfg channel are always ready and are meant for
// idle periods. Reset empties the queue and loads switch_start = 12.0 and
// switch_end = 16.0 in the distance format.
// ----------------------------------------------------------------------------
`include "descreening_integral_kernel_unit_assert.svh"

module descreening_integral_kernel_unit #(
  parameter int unsigned DIST_FRAC_BITS = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  logic [dik_pkg::FIELD_W-1:0]       distance_i,
  input  logic [dik_pkg::FIELD_W-1:0]       radius_screened_i,
  input  logic [dik_pkg::FIELD_W-1:0]       radius_screener_i,
  output logic                              done_o,
  output logic signed [dik_pkg::VALUE_W-1:0] value_o,
  output logic [dik_pkg::STATUS_W-1:0]      status_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [0:0]                        cfg_index_i,
  input  logic [dik_pkg::FIELD_W-1:0]       cfg_data_i
);
  import dik_pkg::*;

  localparam logic [FIELD_W-1:0] START_RST = FIELD_W'(64'd12 << DIST_FRAC_BITS);
  localparam logic [FIELD_W-1:0] END_RST   = FIELD_W'(64'd16 << DIST_FRAC_BITS);

  logic [FIELD_W-1:0] sw_start_q, sw_end_q;
  logic               q_push, q_pop, q_empty, q_full;
  q_item_t            q_in, q_head;
  logic               op_start;
  op_req_t            op_req;
  op_rsp_t            op_rsp;
  logic [VALUE_W-1:0] value_raw;
  status_e            status_raw;

  assign cfg_ready_o = 1'b1;
  assign busy        = q_full;

  // Switching limits; the user must write them only while the unit is idle, as the block does not enforce it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sw_start_q <= START_RST;
      sw_end_q   <= END_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_SWITCH_START: sw_start_q <= cfg_data_i;
        REG_SWITCH_END:   sw_end_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  dik_front u_front (
    .start_i    (start),
    .full_i     (q_full),
    .r_i        (distance_i),
    .a_i        (radius_screened_i),
    .b_i        (radius_screener_i),
    .sw_start_i (sw_start_q),
    .sw_end_i   (sw_end_q),
    .push_o     (q_push),
    .item_o     (q_in)
  );

  dik_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (q_in),
    .pop_i   (q_pop),
    .item_o  (q_head),
    .empty_o (q_empty),
    .full_o  (q_full)
  );

  dik_seq #(
    .DIST_FRAC_BITS (DIST_FRAC_BITS)
  ) u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .item_i     (q_head),
    .empty_i    (q_empty),
    .pop_o      (q_pop),
    .sw_start_i (sw_start_q),
    .sw_end_i   (sw_end_q),
    .op_start_o (op_start),
    .op_req_o   (op_req),
    .op_rsp_i   (op_rsp),
    .done_o     (done_o),
    .value_o    (value_raw),
    .status_o   (status_raw)
  );

  dik_arith u_arith (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (op_start),
    .req_i   (op_req),
    .rsp_o   (op_rsp)
  );

  assign value_o  = $signed(value_raw);
  assign status_o = status_raw;

  // The queue is never written while it is full.
  `DIK_ASSERT_IMPL(a_no_overflow, q_push, !q_full)
  // A zero-radius item leaves the queue and is reported in the next cycle.
  `DIK_ASSERT_NEXT(a_zero_rad_emit, q_pop && q_head.cls == CL_ZERO_RAD,
                   done_o && status_o == ST_ZERO_RADIUS && value_o == '0)
  // A saturated result carries one of the two limit values.
  `DIK_ASSERT_IMPL(a_sat_value, done_o && status_o == ST_SAT,
                   value_raw == OUT_MAX || value_raw == OUT_MIN)

endmodule
